// ===== hdl/assert_macros.svh =====
// assertion helpers included by the rotate core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/rot90_pkg.sv =====
package rot90_pkg;

  localparam int REG_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS = 2'd1;

  localparam logic [REG_W-1:0] DIM_RESET = 8'd128;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              row_end;
    logic              frame_last;
    logic              valid_res;
  } out_word_t;

  // per-item command from the address sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic res_en;
    logic res_valid;
    logic row_end;
    logic frame_last;
  } item_cmd_t;

endpackage

// ===== hdl/rot90_ram.sv =====
module rot90_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/rot90_ctrl.sv =====
module rot90_ctrl #(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [rot90_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rot90_pkg::REG_W-1:0]          cfg_data,
  input  logic                                 acc,
  input  logic                                 req_type,
  output rot90_pkg::item_cmd_t                 cmd,
  output logic [(MAX_ROWS * MAX_COLS > 1 ? $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0] wr_addr,
  output logic [(MAX_ROWS * MAX_COLS > 1 ? $clog2(MAX_ROWS * MAX_COLS) : 1)-1:0] rd_addr
);

  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int AW       = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int RW       = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int CW       = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int ROWS_CAP = MAX_ROWS < 255 ? MAX_ROWS : 255;
  localparam int COLS_CAP = MAX_COLS < 255 ? MAX_COLS : 255;
  localparam int REG_W    = rot90_pkg::REG_W;

  logic [REG_W-1:0] rows_r, rows_nxt;
  logic [REG_W-1:0] cols_r, cols_nxt;
  logic [RW-1:0]    wr_row_r, wr_row_nxt;
  logic [CW-1:0]    wr_col_r, wr_col_nxt;
  logic [AW-1:0]    wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [RW-1:0]    rd_row_r, rd_row_nxt;
  logic [CW-1:0]    rd_col_r, rd_col_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic             ready_r, ready_nxt;

  logic [REG_W-1:0] rows_c, cols_c;
  logic [RW-1:0]    rows_m1;
  logic [CW-1:0]    cols_m1;
  logic             load, fetch;
  logic             wr_last_col, wr_last, wr_base;
  logic [AW-1:0]    base_sel;
  logic             rd_end, rd_last;

  // geometry: zero counts as one, saturate at the store size
  always_comb begin
    if (rows_r == '0) begin
      rows_c = REG_W'(1);
    end else if (int'(rows_r) > ROWS_CAP) begin
      rows_c = REG_W'(ROWS_CAP);
    end else begin
      rows_c = rows_r;
    end
    if (cols_r == '0) begin
      cols_c = REG_W'(1);
    end else if (int'(cols_r) > COLS_CAP) begin
      cols_c = REG_W'(COLS_CAP);
    end else begin
      cols_c = cols_r;
    end
  end

  assign rows_m1 = RW'(rows_c - REG_W'(1));
  assign cols_m1 = CW'(cols_c - REG_W'(1));

  assign load  = acc && (req_type == rot90_pkg::REQ_LOAD);
  assign fetch = acc && (req_type == rot90_pkg::REQ_FETCH);

  assign wr_last_col = (wr_col_r == cols_m1);
  assign wr_last     = wr_last_col && (wr_row_r == rows_m1);
  // start of the bottom source row; output row i begins i pixels along it
  assign wr_base     = (wr_col_r == '0) && (wr_row_r == rows_m1);
  assign base_sel    = wr_base ? wr_addr_r : base_r;

  assign rd_end  = (rd_row_r == rows_m1);
  assign rd_last = rd_end && (rd_col_r == cols_m1);

  always_comb begin
    rows_nxt    = rows_r;
    cols_nxt    = cols_r;
    wr_row_nxt  = wr_row_r;
    wr_col_nxt  = wr_col_r;
    wr_addr_nxt = wr_addr_r;
    base_nxt    = base_r;
    rd_row_nxt  = rd_row_r;
    rd_col_nxt  = rd_col_r;
    rd_addr_nxt = rd_addr_r;
    ready_nxt   = ready_r;
    priority if (cfg_wr_en && ((cfg_index == rot90_pkg::CFG_IDX_ROWS) ||
                               (cfg_index == rot90_pkg::CFG_IDX_COLS))) begin
      if (cfg_index == rot90_pkg::CFG_IDX_ROWS) begin
        rows_nxt = cfg_data;
      end else begin
        cols_nxt = cfg_data;
      end
      wr_row_nxt  = '0;
      wr_col_nxt  = '0;
      wr_addr_nxt = '0;
      rd_row_nxt  = '0;
      rd_col_nxt  = '0;
      ready_nxt   = 1'b0;
    end else if (load) begin
      base_nxt = base_sel;
      if (wr_addr_r == '0) begin
        ready_nxt = 1'b0;
      end
      if (wr_last) begin
        wr_row_nxt  = '0;
        wr_col_nxt  = '0;
        wr_addr_nxt = '0;
        ready_nxt   = 1'b1;
        rd_row_nxt  = '0;
        rd_col_nxt  = '0;
        rd_addr_nxt = base_sel;
      end else begin
        wr_addr_nxt = wr_addr_r + AW'(1);
        if (wr_last_col) begin
          wr_col_nxt = '0;
          wr_row_nxt = wr_row_r + RW'(1);
        end else begin
          wr_col_nxt = wr_col_r + CW'(1);
        end
      end
    end else if (fetch && ready_r) begin
      if (rd_last) begin
        rd_row_nxt  = '0;
        rd_col_nxt  = '0;
        rd_addr_nxt = base_r;
      end else if (rd_end) begin
        rd_row_nxt  = '0;
        rd_col_nxt  = rd_col_r + CW'(1);
        rd_addr_nxt = base_r + AW'(rd_col_r) + AW'(1);
      end else begin
        rd_row_nxt  = rd_row_r + RW'(1);
        rd_addr_nxt = rd_addr_r - AW'(cols_c);
      end
    end else begin
      ready_nxt = ready_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= rot90_pkg::DIM_RESET;
      cols_r    <= rot90_pkg::DIM_RESET;
      wr_row_r  <= '0;
      wr_col_r  <= '0;
      wr_addr_r <= '0;
      rd_row_r  <= '0;
      rd_col_r  <= '0;
      ready_r   <= 1'b0;
    end else begin
      rows_r    <= rows_nxt;
      cols_r    <= cols_nxt;
      wr_row_r  <= wr_row_nxt;
      wr_col_r  <= wr_col_nxt;
      wr_addr_r <= wr_addr_nxt;
      rd_row_r  <= rd_row_nxt;
      rd_col_r  <= rd_col_nxt;
      ready_r   <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  always_comb begin
    cmd.wr_en      = load;
    cmd.rd_en      = fetch && ready_r;
    cmd.res_en     = fetch;
    cmd.res_valid  = ready_r;
    cmd.row_end    = ready_r && rd_end;
    cmd.frame_last = ready_r && rd_last;
  end

  assign wr_addr = wr_addr_r;
  assign rd_addr = rd_addr_r;

endmodule

// ===== hdl/image_rotate_90_clockwise_core.sv =====
// image_rotate_90_clockwise_core: frame buffer that turns an rgb image a quarter
// turn clockwise.
// input channel (in_valid / in_stall / in_data): a load word writes the next
// pixel in raster order, a fetch word reads the next pixel of the rotated
// frame, output row i being source column i taken from the bottom row up.
// result channel (out_valid / out_stall / out_data): one word per fetch, with
// row-end and frame-last marks; valid_res is low and the pixel zero while no
// complete frame is held. loads give no result.
// cfg port: write rows (index 0) or columns (index 1); any such write restarts
// the frame.
// throughput: one word per cycle while in_stall is low, loads and fetches
// mixed, one store write port and one store read port. a fetch result
// passes through the store read register, filled at the accepting edge,
// and then the output register before it shows on out_valid.
// when out_stall holds a result back, one more fetch sits in the store read
// register and in_stall rises until the output register frees.
// reset: geometry returns to 128 by 128, no frame held, positions at the
// start; the pixel store itself is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module image_rotate_90_clockwise_core #(
  parameter int MAX_ROWS     = 128,
  parameter int MAX_COLS     = 128,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rot90_pkg::in_word_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rot90_pkg::out_word_t            out_data,
  input  logic                            cfg_wr_en,
  input  logic [rot90_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rot90_pkg::REG_W-1:0]     cfg_data
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CB     = CHANNEL_BITS;
  localparam int MEM_W  = 3 * CB;
  localparam int CHAN_W = rot90_pkg::CHAN_W;

  rot90_pkg::item_cmd_t  cmd;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [MEM_W-1:0]      wr_data, rd_data;
  logic                  acc;

  logic                  pend_r, pend_nxt;
  logic                  pend_valid_r, pend_valid_nxt;
  logic                  pend_end_r, pend_end_nxt;
  logic                  pend_last_r, pend_last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  rot90_pkg::out_word_t  out_data_r, out_data_nxt;
  logic                  out_load;
  logic                  stray_data;

  assign in_stall = pend_r && out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  assign wr_data = {CB'(in_data.red_in), CB'(in_data.green_in), CB'(in_data.blue_in)};

  rot90_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .req_type  (in_data.req_type),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  rot90_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // store read register holds while no store read is issued; out_load moves a pending result on once the output is free
  assign out_load = pend_r && (!out_valid_r || !out_stall);

  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    pend_end_nxt   = pend_end_r;
    pend_last_nxt  = pend_last_r;
    if (cmd.res_en) begin
      pend_nxt       = 1'b1;
      pend_valid_nxt = cmd.res_valid;
      pend_end_nxt   = cmd.row_end;
      pend_last_nxt  = cmd.frame_last;
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (pend_valid_r) begin
        out_data_nxt.red_out   = CHAN_W'(rd_data[3*CB-1:2*CB]);
        out_data_nxt.green_out = CHAN_W'(rd_data[2*CB-1:CB]);
        out_data_nxt.blue_out  = CHAN_W'(rd_data[CB-1:0]);
      end else begin
        out_data_nxt.red_out   = '0;
        out_data_nxt.green_out = '0;
        out_data_nxt.blue_out  = '0;
      end
      out_data_nxt.row_end    = pend_end_r;
      out_data_nxt.frame_last = pend_last_r;
      out_data_nxt.valid_res  = pend_valid_r;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_valid_r <= pend_valid_nxt;
    pend_end_r   <= pend_end_nxt;
    pend_last_r  <= pend_last_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a word without a frame carrying anything but zeros
  assign stray_data = !out_data_r.valid_res &&
                      ((out_data_r.red_out != '0) || (out_data_r.green_out != '0) ||
                       (out_data_r.blue_out != '0) || out_data_r.row_end ||
                       out_data_r.frame_last);

  `ASSERT_CLK(a_fetch_pends, clk, rst_n, cmd.res_en |=> pend_r, "fetch word lost before read")
  `ASSERT_CLK(a_pend_held, clk, rst_n, (pend_r && in_stall) |=> pend_r, "pending fetch dropped")
  `ASSERT_NEVER(a_no_frame_zero, clk, rst_n, out_valid_r && stray_data, "frameless word not zero")
  `ASSERT_CLK(a_load_no_read, clk, rst_n, cmd.wr_en |-> !cmd.rd_en, "store read issued on a load")

endmodule

// ===== tb/rotated_pixel_checker.sv =====
`timescale 1ns / 1ps

module rotated_pixel_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  rot90_pkg::in_word_t             in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  rot90_pkg::out_word_t            out_data,
  input  logic                            cfg_wr_en,
  input  logic [rot90_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rot90_pkg::REG_W-1:0]     cfg_data,
  output int                              mismatches,
  output int                              pixels_owed
);
  import rot90_pkg::*;

  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;

  logic [3*CHAN_W-1:0] pixel_mem [MAX_ROWS*MAX_COLS];
  logic [REG_W-1:0]    rows_reg;
  logic [REG_W-1:0]    cols_reg;
  int                  load_pos;
  int                  read_col;
  int                  read_pos;
  bit                  frame_full;
  out_word_t           owed_pixels [$];
  out_word_t           want;
  int                  fail_total;
  bit                  bad;

  function automatic int clamp_extent(logic [REG_W-1:0] v, int limit);
    if (v == '0) return 1;
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic void restart_frame();
    load_pos   = 0;
    read_col   = 0;
    read_pos   = 0;
    frame_full = 1'b0;
  endfunction

  function automatic void store_pixel(in_word_t w);
    int total;
    int a;
    total = clamp_extent(rows_reg, MAX_ROWS) * clamp_extent(cols_reg, MAX_COLS);
    a = (load_pos >= total) ? total - 1 : load_pos;
    if (a == 0) frame_full = 1'b0;
    pixel_mem[a] = {w.red_in, w.green_in, w.blue_in};
    if (a == total - 1) begin
      load_pos   = 0;
      frame_full = 1'b1;
      read_col   = 0;
      read_pos   = 0;
    end else begin
      load_pos = a + 1;
    end
  endfunction

  // output row is a source column, walked from the bottom source row upwards
  function automatic out_word_t next_rotated_pixel();
    int rows;
    int cols;
    int c;
    int k;
    out_word_t px;
    px = '0;
    if (!frame_full) return px;
    rows = clamp_extent(rows_reg, MAX_ROWS);
    cols = clamp_extent(cols_reg, MAX_COLS);
    c = (read_col >= cols) ? cols - 1 : read_col;
    k = (read_pos >= rows) ? rows - 1 : read_pos;
    {px.red_out, px.green_out, px.blue_out} = pixel_mem[(rows - 1 - k) * cols + c];
    px.row_end    = (k == rows - 1);
    px.frame_last = px.row_end && (c == cols - 1);
    px.valid_res  = 1'b1;
    if (px.row_end) begin
      read_pos = 0;
      read_col = px.frame_last ? 0 : c + 1;
    end else begin
      read_pos = k + 1;
      read_col = c;
    end
    return px;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      restart_frame();
      owed_pixels.delete();
      fail_total = 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_IDX_ROWS) begin
          rows_reg = cfg_data;
          restart_frame();
        end else if (cfg_index == CFG_IDX_COLS) begin
          cols_reg = cfg_data;
          restart_frame();
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.req_type == REQ_LOAD) begin
          store_pixel(in_data);
        end else begin
          owed_pixels.push_back(next_rotated_pixel());
        end
      end
      if (out_valid && !out_stall) begin
        if (owed_pixels.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: result word with no fetch waiting: %h", $time, out_data);
        end else begin
          want = owed_pixels.pop_front();
          bad = (out_data.red_out !== want.red_out) ||
                (out_data.green_out !== want.green_out) ||
                (out_data.blue_out !== want.blue_out) ||
                (out_data.row_end !== want.row_end) ||
                (out_data.frame_last !== want.frame_last) ||
                (out_data.valid_res !== want.valid_res);
          if (bad) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("%0t: expected rgb %h %h %h row_end %b frame_last %b valid %b",
                       $time, want.red_out, want.green_out, want.blue_out,
                       want.row_end, want.frame_last, want.valid_res);
              $display("%0t: actual   rgb %h %h %h row_end %b frame_last %b valid %b",
                       $time, out_data.red_out, out_data.green_out, out_data.blue_out,
                       out_data.row_end, out_data.frame_last, out_data.valid_res);
            end
          end
        end
      end
    end
    mismatches  <= fail_total;
    pixels_owed <= owed_pixels.size();
  end

endmodule

// ===== tb/image_rotate_90_clockwise_core_tb.sv =====
`timescale 1ns / 1ps

module image_rotate_90_clockwise_core_tb;
  import rot90_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_ROWS;
  logic [REG_W-1:0]     cfg_data  = '0;

  int mismatches;
  int pixels_owed;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent    = 0;
  int quiet_cycles  = 0;

  image_rotate_90_clockwise_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rotated_pixel_checker pixel_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .pixels_owed (pixels_owed)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("image_rotate_90_clockwise_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_word_t random_word(input logic kind);
    in_word_t w;
    w.req_type = kind;
    w.red_in   = 8'($urandom_range(0, 255));
    w.green_in = 8'($urandom_range(0, 255));
    w.blue_in  = 8'($urandom_range(0, 255));
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    bit taken;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    words_sent++;
  endtask

  task automatic load_pixels(input int n, input int noise_pct);
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(random_word(REQ_FETCH));
      send_word(random_word(REQ_LOAD));
    end
  endtask

  task automatic fetch_pixels(input int n);
    repeat (n) send_word(random_word(REQ_FETCH));
  endtask

  // hold the sender until every fetch has been answered and loads have settled
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_geometry(input logic [REG_W-1:0] r, input logic [REG_W-1:0] c);
    drain();
    write_reg(CFG_IDX_ROWS, r);
    write_reg(CFG_IDX_COLS, c);
  endtask

  task automatic run_frames(input logic [REG_W-1:0] r, input logic [REG_W-1:0] c);
    int total;
    set_geometry(r, c);
    total = ((r == '0) ? 1 : int'(r)) * ((c == '0) ? 1 : int'(c));
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 9))
        7: begin
          // broken frame, a partial load followed by one to three fetches
          load_pixels($urandom_range(0, total - 1), 0);
          fetch_pixels($urandom_range(1, 3));
        end
        8: begin
          repeat (8) send_word(random_word(1'($urandom_range(0, 1))));
        end
        default: begin
          load_pixels(total, 10);
          fetch_pixels($urandom_range(1, 2 * total + 1));
        end
      endcase
    end
  endtask

  task automatic random_phase(input int quota);
    int stop_at;
    logic [REG_W-1:0] r;
    logic [REG_W-1:0] c;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      r = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      c = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 6));
      run_frames(r, c);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 79;

    // nothing held after reset
    fetch_pixels(1);
    set_geometry(8'd2, 8'd3);
    send_word(in_word_t'{REQ_LOAD, 8'hFF, 8'hFF, 8'hFF});
    send_word(in_word_t'{REQ_LOAD, 8'h00, 8'h00, 8'h00});
    send_word(in_word_t'{REQ_LOAD, 8'hAA, 8'h55, 8'h0F});
    fetch_pixels(1);
    load_pixels(3, 0);
    // whole frame then wrap
    fetch_pixels(7);
    // first pixel of a new frame drops the frame
    load_pixels(1, 0);
    fetch_pixels(1);
    load_pixels(5, 0);
    drain();
    write_reg(CFG_IDX_SPARE_LO, 8'hFF);
    write_reg(CFG_IDX_SPARE_HI, 8'h00);
    fetch_pixels(2);

    random_phase(35);

    send_idle_pct = 79;
    recv_idle_pct = 34;
    random_phase(35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // tall single column and wide single row, both at the maximum extent
    set_geometry(8'd255, 8'd0);
    load_pixels(128, 0);
    fetch_pixels(4);
    set_geometry(8'd0, 8'd255);
    load_pixels(128, 0);
    fetch_pixels(4);
    set_geometry(8'd128, 8'd128);
    fetch_pixels(1);

    drain();
    if (mismatches == 0) begin
      $display("image_rotate_90_clockwise_core test passed");
    end else begin
      $display("image_rotate_90_clockwise_core test failed");
    end
    $finish;
  end

endmodule
